FILE: rtl/averaging_window_alarm_monitor_assert.svh
// ---------------------------------------------------------------------------
// averaging window alarm monitor assertion macros
// concurrent checks on the rising clock edge, off while reset is low
// ---------------------------------------------------------------------------
`ifndef AVERAGING_WINDOW_ALARM_MONITOR_ASSERT_SVH
`define AVERAGING_WINDOW_ALARM_MONITOR_ASSERT_SVH

`ifndef SYNTHESIS

`define AWAM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`define AWAM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define AWAM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)

`define AWAM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: rtl/awam_pkg.sv
// ---------------------------------------------------------------------------
// awam_pkg
// types, constants and codes shared by the averaging window alarm monitor
// ---------------------------------------------------------------------------
package awam_pkg;

    localparam int CHANNELS        = 4;
    localparam int SAMPLE_W        = 14;
    localparam int THR_W           = 16;
    localparam int CFG_W           = 64;
    localparam int CFG_IDX_W       = 3;
    localparam int TIME_W          = 32;
    localparam int UPTIME_W        = 16;
    localparam int SETS_W          = 16;
    localparam int WD_LIMIT_W      = 26;
    localparam int UPT_RECIP_W     = 29;
    localparam int UPT_SHIFT       = 38;
    localparam int MAX_AVERAGE_DEF = 64;

    localparam logic [15:0] INTERVAL_MIN   = 16'd10;
    localparam logic [15:0] INTERVAL_RESET = 16'd100;
    localparam int          AVG_DEFAULT    = 8;
    localparam int          MS_PER_S       = 1000;

    // ceil(2^38 / 1000), exact for every 32-bit dividend
    localparam logic [UPT_RECIP_W-1:0] UPT_RECIP = 29'd274877907;

    localparam logic [THR_W-1:0] THR_HIGH_RESET = 16'd9000;
    localparam logic [THR_W-1:0] THR_LOW_RESET  = 16'd500;
    localparam logic [CFG_W-1:0] HIGH_RESET     = {CHANNELS{THR_HIGH_RESET}};
    localparam logic [CFG_W-1:0] LOW_RESET      = {CHANNELS{THR_LOW_RESET}};

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_THR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_THR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AVG_CNT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WATCHDOG = 3'd4;

    localparam logic OP_TICK     = 1'b0;
    localparam logic OP_SAMPLE   = 1'b1;
    localparam logic KIND_MEAS   = 1'b0;
    localparam logic KIND_RESET  = 1'b1;

    typedef struct packed {
        logic                operation;
        logic [TIME_W-1:0]   tick_ms;
        logic [TIME_W-1:0]   frames_seen;
        logic [SAMPLE_W-1:0] sample_a;
        logic [SAMPLE_W-1:0] sample_b;
        logic [SAMPLE_W-1:0] sample_c;
        logic [SAMPLE_W-1:0] sample_d;
    } t_in_item;

    typedef struct packed {
        logic                kind;
        logic [SAMPLE_W-1:0] average_a;
        logic [SAMPLE_W-1:0] average_b;
        logic [SAMPLE_W-1:0] average_c;
        logic [SAMPLE_W-1:0] average_d;
        logic [CHANNELS-1:0] alarm_bits;
        logic [SETS_W-1:0]   sample_total;
        logic [UPTIME_W-1:0] uptime_seconds;
    } t_out_item;

    typedef struct packed {
        logic clear;
        logic add;
        logic start;
    } t_lane_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_DIV
    } t_state;

endpackage

FILE: rtl/awam_div.sv
// ---------------------------------------------------------------------------
// awam_div
// restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
module awam_div #(
    parameter int DW = 20,
    parameter int VW = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_busy,
    output logic [DW-1:0] o_quotient
);

    localparam int CW = $clog2(DW + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [VW-1:0] r_rem;
    logic [DW-1:0] r_quo;

    logic [VW:0]   shifted;
    logic [VW:0]   diff;
    logic          fits;
    logic [VW-1:0] n_rem;
    logic [DW-1:0] n_quo;

    always_comb begin
        shifted = {r_rem, r_quo[DW-1]};
        diff    = shifted - {1'b0, i_divisor};
        fits    = shifted >= {1'b0, i_divisor};
        n_rem   = fits ? diff[VW-1:0] : shifted[VW-1:0];
        n_quo   = {r_quo[DW-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(DW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

FILE: rtl/awam_lane.sv
// ---------------------------------------------------------------------------
// awam_lane
// one channel: running sum, average divider and window compare
// ---------------------------------------------------------------------------
module awam_lane #(
    parameter int SUM_W = 20,
    parameter int CNT_W = 7
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  awam_pkg::t_lane_ctl           i_ctl,
    input  logic [awam_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [CNT_W-1:0]              i_len,
    input  logic [awam_pkg::THR_W-1:0]    i_high,
    input  logic [awam_pkg::THR_W-1:0]    i_low,
    output logic                          o_busy,
    output logic [awam_pkg::SAMPLE_W-1:0] o_average,
    output logic                          o_alarm
);

    import awam_pkg::*;

    localparam int CMP_W = (SUM_W > THR_W) ? SUM_W : THR_W;

    logic [SUM_W-1:0] r_sum;
    logic [SUM_W-1:0] quo;
    logic [CMP_W-1:0] avg_x;
    logic [CMP_W-1:0] hi_x;
    logic [CMP_W-1:0] lo_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_ctl.clear) begin
            r_sum <= '0;
        end else if (i_ctl.add) begin
            r_sum <= r_sum + SUM_W'(i_sample);
        end
    end

    awam_div #(
        .DW(SUM_W),
        .VW(CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_ctl.start),
        .i_dividend (r_sum),
        .i_divisor  (i_len),
        .o_busy     (o_busy),
        .o_quotient (quo)
    );

    assign avg_x     = CMP_W'(quo);
    assign hi_x      = CMP_W'(i_high);
    assign lo_x      = CMP_W'(i_low);
    assign o_alarm   = (avg_x > hi_x) || (avg_x < lo_x);
    assign o_average = SAMPLE_W'(quo);

endmodule

FILE: rtl/averaging_window_alarm_monitor.sv
// ---------------------------------------------------------------------------
// averaging_window_alarm_monitor
// four-lane averaging voltage monitor with window alarms and host watchdog
// ---------------------------------------------------------------------------
//  channel   valid         stall         payload
//  input     i_in_valid    o_in_stall    i_in_item  (t_in_item)
//  output    o_out_valid   i_out_stall   o_out_item (t_out_item)
//  config    i_cfg_we      -             i_cfg_index, i_cfg_data
//
//  a tick item or a non-final sample item is taken without a stall of its own
//  the final sample of a capture stalls the input through the start state,
//  20 lane divide steps (one per sum bit), then the load of the result
//  uptime is a registered reciprocal multiply in the start cycle
//  input also stalls while a stalled result waits; an item is taken as it drains
//  synchronous active-low reset restores register defaults and closes any capture
// ---------------------------------------------------------------------------
`include "averaging_window_alarm_monitor_assert.svh"

module averaging_window_alarm_monitor #(
    parameter int MAX_AVERAGE = awam_pkg::MAX_AVERAGE_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  awam_pkg::t_in_item             i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output awam_pkg::t_out_item            o_out_item,
    input  logic                           i_cfg_we,
    input  logic [awam_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [awam_pkg::CFG_W-1:0]     i_cfg_data
);

    import awam_pkg::*;

    localparam int CNT_MAX = (MAX_AVERAGE > AVG_DEFAULT) ? MAX_AVERAGE : AVG_DEFAULT;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);
    localparam int SUM_W   = SAMPLE_W + $clog2(CNT_MAX);
    localparam int UPT_PROD_W = TIME_W + UPT_RECIP_W;
    localparam logic [15:0]         MAX_AVG_16 = 16'(MAX_AVERAGE);
    localparam logic [WD_LIMIT_W-1:0] WD_SCALE = WD_LIMIT_W'(MS_PER_S);

    // configuration
    logic [CFG_W-1:0]      r_high;
    logic [CFG_W-1:0]      r_low;
    logic [15:0]           r_interval;
    logic [CNT_W-1:0]      r_avg_eff;
    logic                  r_wd_en;
    logic [WD_LIMIT_W-1:0] r_wd_limit;
    logic [15:0]           cfg_val16;

    // monitor state
    t_state              r_state;
    t_state              n_state;
    logic [TIME_W-1:0]   r_update_time;
    logic [TIME_W-1:0]   r_last_frame;
    logic [TIME_W-1:0]   r_prev_frames;
    logic                r_open;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    r_len;
    logic [SETS_W-1:0]   r_sets;
    logic                r_out_valid;
    t_out_item           r_out;

    logic                in_acc;
    logic                is_tick;
    logic [TIME_W-1:0]   elapsed_upd;
    logic [TIME_W-1:0]   elapsed_wd;
    logic                tick_due;
    logic                frames_new;
    logic                wd_fire;
    logic                tick_take;
    logic                sample_take;
    logic [CNT_W-1:0]    cnt_inc;
    logic                sample_last;
    logic                out_free;
    logic                div_start;
    logic                load_meas;
    logic                load_reset;
    logic                div_busy_any;

    t_lane_ctl           lane_ctl;
    logic [SAMPLE_W-1:0] samples   [CHANNELS];
    logic [SAMPLE_W-1:0] lane_avg  [CHANNELS];
    logic [CHANNELS-1:0] lane_alarm;
    logic [CHANNELS-1:0] lane_busy;
    logic [UPT_PROD_W-1:0] upt_prod;
    logic [UPTIME_W-1:0]   r_uptime;

    // configuration port
    assign cfg_val16 = i_cfg_data[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high     <= HIGH_RESET;
            r_low      <= LOW_RESET;
            r_interval <= INTERVAL_RESET;
            r_avg_eff  <= CNT_W'(AVG_DEFAULT);
            r_wd_en    <= 1'b0;
            r_wd_limit <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_HIGH_THR: r_high <= i_cfg_data;
                REG_LOW_THR:  r_low  <= i_cfg_data;
                REG_INTERVAL: begin
                    r_interval <= (cfg_val16 < INTERVAL_MIN) ? INTERVAL_MIN : cfg_val16;
                end
                REG_AVG_CNT: begin
                    if (cfg_val16 == 16'd0 || cfg_val16 > MAX_AVG_16) begin
                        r_avg_eff <= CNT_W'(AVG_DEFAULT);
                    end else begin
                        r_avg_eff <= CNT_W'(cfg_val16);
                    end
                end
                REG_WATCHDOG: begin
                    r_wd_en    <= cfg_val16 != 16'd0;
                    r_wd_limit <= WD_LIMIT_W'(cfg_val16) * WD_SCALE;
                end
                default: ;
            endcase
        end
    end

    // input decode
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign is_tick     = i_in_item.operation == OP_TICK;

    assign elapsed_upd = i_in_item.tick_ms - r_update_time;
    assign tick_due    = elapsed_upd >= TIME_W'(r_interval);
    assign frames_new  = (i_in_item.frames_seen != '0)
                      && (i_in_item.frames_seen != r_prev_frames);
    assign elapsed_wd  = i_in_item.tick_ms - r_last_frame;
    assign wd_fire     = r_wd_en && !frames_new && (elapsed_wd > TIME_W'(r_wd_limit));

    assign tick_take   = in_acc && is_tick && tick_due;
    assign sample_take = in_acc && !is_tick && r_open;
    assign cnt_inc     = r_count + CNT_W'(1);
    assign sample_last = cnt_inc == r_len;
    assign load_reset  = tick_take && wd_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_update_time <= '0;
            r_last_frame  <= '0;
            r_prev_frames <= '0;
            r_open        <= 1'b0;
            r_count       <= '0;
            r_len         <= '0;
            r_sets        <= '0;
        end else if (tick_take) begin
            r_update_time <= i_in_item.tick_ms;
            if (r_wd_en && frames_new) begin
                r_prev_frames <= i_in_item.frames_seen;
                r_last_frame  <= i_in_item.tick_ms;
            end
            r_open  <= 1'b1;
            r_count <= '0;
            r_len   <= r_avg_eff;
        end else if (sample_take) begin
            r_count <= cnt_inc;
            r_sets  <= r_sets + SETS_W'(1);
            if (sample_last) begin
                r_open <= 1'b0;
            end
        end
    end

    // sequencer for the end of a capture
    assign div_busy_any = |lane_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        load_meas = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (sample_take && sample_last) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                div_start = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (!div_busy_any && out_free) begin
                    load_meas = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // lanes
    assign lane_ctl.clear = tick_take;
    assign lane_ctl.add   = sample_take;
    assign lane_ctl.start = div_start;

    assign samples[0] = i_in_item.sample_a;
    assign samples[1] = i_in_item.sample_b;
    assign samples[2] = i_in_item.sample_c;
    assign samples[3] = i_in_item.sample_d;

    for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
        awam_lane #(
            .SUM_W(SUM_W),
            .CNT_W(CNT_W)
        ) u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (lane_ctl),
            .i_sample  (samples[c]),
            .i_len     (r_len),
            .i_high    (r_high[THR_W*c +: THR_W]),
            .i_low     (r_low[THR_W*c +: THR_W]),
            .o_busy    (lane_busy[c]),
            .o_average (lane_avg[c]),
            .o_alarm   (lane_alarm[c])
        );
    end

    // uptime in seconds of the opening tick
    assign upt_prod = UPT_PROD_W'(r_update_time) * UPT_PROD_W'(UPT_RECIP);

    always_ff @(posedge i_clk) begin
        if (div_start) begin
            r_uptime <= upt_prod[UPT_SHIFT +: UPTIME_W];
        end
    end

    // merge and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_meas || load_reset) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_reset) begin
            r_out <= '{kind: KIND_RESET, default: '0};
        end else if (load_meas) begin
            r_out.kind           <= KIND_MEAS;
            r_out.average_a      <= lane_avg[0];
            r_out.average_b      <= lane_avg[1];
            r_out.average_c      <= lane_avg[2];
            r_out.average_d      <= lane_avg[3];
            r_out.alarm_bits     <= lane_alarm;
            r_out.sample_total   <= r_sets;
            r_out.uptime_seconds <= r_uptime;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // checks
    `AWAM_ASSERT_NOW(a_count_in_capture, i_clk, i_rst_n, 1'b1, r_count <= r_len, "capture count passed its length")
    `AWAM_ASSERT_NEXT(a_meas_after_div, i_clk, i_rst_n, load_meas, o_out_valid && o_out_item.kind == KIND_MEAS, "measurement not presented after divide")
    `AWAM_ASSERT_NEXT(a_no_reset_wd_off, i_clk, i_rst_n, in_acc && is_tick && !r_wd_en, !(o_out_valid && o_out_item.kind == KIND_RESET), "reset request with watchdog off")

endmodule

FILE: verif/averaging_window_alarm_monitor_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// averaging_window_alarm_monitor_test
// drives tick and sample items into the monitor under several register
// settings, predicts every measurement and watchdog result in a small model
// class and checks each result in order; both sides idle and stall at random
// ---------------------------------------------------------------------------
module averaging_window_alarm_monitor_test;
    import awam_pkg::*;

    localparam int HALF_PERIOD       = 2;
    localparam int SETTLE_CYCLES     = 40;
    localparam int HOLD_CYCLES       = 300;
    localparam int CYCLE_LIMIT       = 500000;
    localparam int ITEMS_PER_SETTING = 205;
    localparam int NUM_SETTINGS      = 6;
    localparam int MAX_SHOWN         = 10;

    class window_monitor_model;
        logic [CFG_W-1:0]    high_limits;
        logic [CFG_W-1:0]    low_limits;
        logic [15:0]         interval_ms;
        logic [15:0]         avg_request;
        logic [15:0]         wd_seconds;
        logic [TIME_W-1:0]   last_update;
        logic [TIME_W-1:0]   update_ms;
        logic [TIME_W-1:0]   last_frame_ms;
        logic [TIME_W-1:0]   prev_frames;
        bit                  capture_open;
        logic [6:0]          captured;
        logic [6:0]          capture_len;
        logic [19:0]         sums [CHANNELS];
        logic [SETS_W-1:0]   sets_taken;
        t_out_item           expected_reports [$];
        int unsigned         mismatches;
        int unsigned         effective;
        int unsigned         measurements;
        int unsigned         watchdog_resets;

        function new();
            high_limits     = HIGH_RESET;
            low_limits      = LOW_RESET;
            interval_ms     = INTERVAL_RESET;
            avg_request     = 16'(AVG_DEFAULT);
            wd_seconds      = '0;
            last_update     = '0;
            update_ms       = '0;
            last_frame_ms   = '0;
            prev_frames     = '0;
            capture_open    = 1'b0;
            captured        = '0;
            capture_len     = '0;
            sets_taken      = '0;
            mismatches      = 0;
            effective       = 0;
            measurements    = 0;
            watchdog_resets = 0;
            for (int c = 0; c < CHANNELS; c++) sums[c] = '0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] data);
            case (index)
                REG_HIGH_THR: high_limits = data;
                REG_LOW_THR:  low_limits  = data;
                REG_INTERVAL: interval_ms = data[15:0];
                REG_AVG_CNT:  avg_request = data[15:0];
                REG_WATCHDOG: wd_seconds  = data[15:0];
                default: ;
            endcase
        endfunction

        function void note_failure(string msg);
            mismatches++;
            if (mismatches <= MAX_SHOWN) $display("%s", msg);
        endfunction

        // returns 1 when the item changed state or produced a result
        function bit accept_item(t_in_item it);
            logic [TIME_W-1:0]   span;
            logic [TIME_W-1:0]   gap;
            logic [TIME_W-1:0]   limit;
            logic [TIME_W-1:0]   up;
            logic [19:0]         mean;
            logic [SAMPLE_W-1:0] rd [CHANNELS];
            logic [SAMPLE_W-1:0] means [CHANNELS];
            logic [CHANNELS-1:0] alarms;
            int unsigned         sets;
            t_out_item           report;

            if (it.operation == OP_TICK) begin
                span = TIME_W'((interval_ms < INTERVAL_MIN) ? INTERVAL_MIN : interval_ms);
                gap = it.tick_ms - last_update;
                if (gap < span) return 1'b0;
                last_update = it.tick_ms;
                update_ms = it.tick_ms;
                if (wd_seconds != 0) begin
                    if (it.frames_seen != 0 && it.frames_seen != prev_frames) begin
                        prev_frames = it.frames_seen;
                        last_frame_ms = it.tick_ms;
                    end
                    limit = TIME_W'(wd_seconds) * TIME_W'(MS_PER_S);
                    gap = it.tick_ms - last_frame_ms;
                    if (gap > limit) begin
                        report = '0;
                        report.kind = KIND_RESET;
                        expected_reports.push_back(report);
                    end
                end
                sets = {16'd0, avg_request};
                if (sets == 0 || sets > MAX_AVERAGE_DEF) sets = AVG_DEFAULT;
                capture_len = sets[6:0];
                capture_open = 1'b1;
                captured = '0;
                for (int c = 0; c < CHANNELS; c++) sums[c] = '0;
                effective++;
                return 1'b1;
            end

            if (!capture_open) return 1'b0;
            rd[0] = it.sample_a;
            rd[1] = it.sample_b;
            rd[2] = it.sample_c;
            rd[3] = it.sample_d;
            for (int c = 0; c < CHANNELS; c++) sums[c] = sums[c] + 20'(rd[c]);
            captured++;
            sets_taken++;
            effective++;
            if (captured < capture_len) return 1'b1;

            capture_open = 1'b0;
            alarms = '0;
            for (int c = 0; c < CHANNELS; c++) begin
                mean = sums[c] / 20'(capture_len);
                means[c] = mean[SAMPLE_W-1:0];
                if (mean > high_limits[THR_W*c +: THR_W] || mean < low_limits[THR_W*c +: THR_W])
                    alarms[c] = 1'b1;
            end
            up = update_ms / MS_PER_S;
            report = '0;
            report.kind = KIND_MEAS;
            report.average_a = means[0];
            report.average_b = means[1];
            report.average_c = means[2];
            report.average_d = means[3];
            report.alarm_bits = alarms;
            report.sample_total = sets_taken;
            report.uptime_seconds = up[UPTIME_W-1:0];
            expected_reports.push_back(report);
            return 1'b1;
        endfunction

        function void check_report(t_out_item got);
            t_out_item want;

            if (got.kind == KIND_RESET) watchdog_resets++;
            else measurements++;
            if (expected_reports.size() == 0) begin
                note_failure($sformatf("unexpected result: kind %0d avg %0d %0d %0d %0d",
                    got.kind, got.average_a, got.average_b, got.average_c, got.average_d));
                return;
            end
            want = expected_reports.pop_front();
            if (got.kind !== want.kind || got.average_a !== want.average_a ||
                got.average_b !== want.average_b || got.average_c !== want.average_c ||
                got.average_d !== want.average_d || got.alarm_bits !== want.alarm_bits ||
                got.sample_total !== want.sample_total ||
                got.uptime_seconds !== want.uptime_seconds) begin
                note_failure($sformatf({"result mismatch\n",
                    "  expected kind %0d avg %0d %0d %0d %0d alarms %h total %0d uptime %0d\n",
                    "  actual   kind %0d avg %0d %0d %0d %0d alarms %h total %0d uptime %0d"},
                    want.kind, want.average_a, want.average_b, want.average_c,
                    want.average_d, want.alarm_bits, want.sample_total, want.uptime_seconds,
                    got.kind, got.average_a, got.average_b, got.average_c,
                    got.average_d, got.alarm_bits, got.sample_total, got.uptime_seconds));
            end
        endfunction

        function int unsigned pending();
            return expected_reports.size();
        endfunction
    endclass

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_in_item             i_in_item   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_item            o_out_item;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;

    window_monitor_model model;
    int unsigned         send_idle_pct = 21;
    int unsigned         recv_idle_pct = 81;
    int unsigned         items_sent    = 0;
    int unsigned         cycles        = 0;
    bit                  hold_request  = 1'b0;
    int unsigned         hold_left     = 0;
    logic [TIME_W-1:0]   cur_ms        = '0;
    logic [TIME_W-1:0]   last_frames   = '0;

    averaging_window_alarm_monitor DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #HALF_PERIOD i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("averaging_window_alarm_monitor test failed");
            $finish;
        end
    end

    // long hold-off runs here, counted in its own cycles
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) model.check_report(o_out_item);
    end

    function automatic logic [SAMPLE_W-1:0] reading();
        logic [31:0] r;
        r = ($urandom_range(9) == 0) ? $urandom : $urandom_range(10000);
        return r[SAMPLE_W-1:0];
    endfunction

    function automatic t_in_item tick_item(logic [TIME_W-1:0] ms, logic [TIME_W-1:0] frames);
        t_in_item it;
        logic [31:0] r;
        it.operation = OP_TICK;
        it.tick_ms = ms;
        it.frames_seen = frames;
        r = $urandom;
        it.sample_a = r[13:0];
        it.sample_b = r[27:14];
        r = $urandom;
        it.sample_c = r[13:0];
        it.sample_d = r[27:14];
        return it;
    endfunction

    function automatic t_in_item sample_item(logic [SAMPLE_W-1:0] a, logic [SAMPLE_W-1:0] b,
                                             logic [SAMPLE_W-1:0] c, logic [SAMPLE_W-1:0] d);
        t_in_item it;
        it.operation = OP_SAMPLE;
        it.tick_ms = $urandom;
        it.frames_seen = $urandom;
        it.sample_a = a;
        it.sample_b = b;
        it.sample_c = c;
        it.sample_d = d;
        return it;
    endfunction

    function automatic logic [TIME_W-1:0] eff_interval();
        return TIME_W'((model.interval_ms < INTERVAL_MIN) ? INTERVAL_MIN : model.interval_ms);
    endfunction

    function automatic int unsigned eff_sets();
        if (model.avg_request == 0 || model.avg_request > MAX_AVERAGE_DEF) return AVG_DEFAULT;
        return {16'd0, model.avg_request};
    endfunction

    function automatic logic [TIME_W-1:0] next_frames();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 20) return '0;
        if (pick < 65) return last_frames;
        last_frames = $urandom;
        return last_frames;
    endfunction

    function automatic logic [CFG_W-1:0] random_limits(bit upper);
        logic [CFG_W-1:0] v;
        for (int c = 0; c < CHANNELS; c++) begin
            if ($urandom_range(7) == 0) v[THR_W*c +: THR_W] = THR_W'($urandom);
            else if (upper) v[THR_W*c +: THR_W] = THR_W'($urandom_range(4000, 16383));
            else v[THR_W*c +: THR_W] = THR_W'($urandom_range(0, 6000));
        end
        return v;
    endfunction

    task automatic send_item(input t_in_item it);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
        void'(model.accept_item(it));
    endtask

    task automatic send_capture(input int unsigned sets);
        logic [TIME_W-1:0] step;
        step = eff_interval() + $urandom_range(0, eff_interval());
        if ($urandom_range(9) == 0) step += $urandom_range(0, 4000);
        cur_ms += step;
        send_item(tick_item(cur_ms, next_frames()));
        repeat (sets) send_item(sample_item(reading(), reading(), reading(), reading()));
    endtask

    // stop offering and let every expected result drain
    task automatic quiesce();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (model.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        model.set_register(index, data);
    endtask

    task automatic write_settings(input logic [CFG_W-1:0] high, input logic [CFG_W-1:0] low,
                                  input logic [15:0] interval, input logic [15:0] count,
                                  input logic [15:0] watchdog);
        write_register(REG_HIGH_THR, high);
        write_register(REG_LOW_THR, low);
        write_register(REG_INTERVAL, {48'd0, interval});
        write_register(REG_AVG_CNT, {48'd0, count});
        write_register(REG_WATCHDOG, {48'd0, watchdog});
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_random(input int unsigned goal);
        int unsigned pick;
        while (model.effective < goal) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                send_capture(eff_sets());
            end else if (pick < 78) begin
                send_capture($urandom_range(0, eff_sets() - 1));
            end else if (pick < 88) begin
                send_item(sample_item(reading(), reading(), reading(), reading()));
            end else if (pick < 95) begin
                send_item(tick_item(cur_ms + $urandom_range(0, eff_interval() - 1),
                                    next_frames()));
            end else begin
                cur_ms = $urandom;
                send_item(tick_item(cur_ms, next_frames()));
            end
        end
    endtask

    task automatic apply_setting(input int stage);
        case (stage)
            0: write_settings(HIGH_RESET, LOW_RESET, 16'd100, 16'd8, 16'd0);
            1: write_settings(random_limits(1'b1), random_limits(1'b0), 16'd10, 16'd1, 16'd2);
            2: write_settings('0, '1, 16'hFFFF, 16'd64, 16'hFFFF);
            3: write_settings(random_limits(1'b1), random_limits(1'b0), 16'd3, 16'd0, 16'd1);
            4: write_settings('1, '0, 16'd500, 16'hFFFF, 16'd0);
            default: write_settings(random_limits(1'b1), random_limits(1'b0), 16'd37,
                                    16'($urandom_range(2, 6)), 16'd3);
        endcase
        send_idle_pct = (stage < 2) ? 21 : (stage < 4) ? 81 : 0;
        recv_idle_pct = (stage < 2) ? 81 : (stage < 4) ? 21 : 0;
    endtask

    initial begin
        int unsigned goal;

        model = new();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        // directed items: idle capture, short interval, restarts, watchdog, wrap
        write_settings(64'hFFFF_0000_1388_2328, 64'h0000_0000_1770_01F4, 16'd0, 16'd2, 16'd1);
        send_item(sample_item(14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF));
        send_item(tick_item(32'd5, 32'd0));
        send_item(tick_item(32'd10, 32'd0));
        send_item(sample_item(14'd0, 14'd0, 14'd0, 14'd0));
        send_item(tick_item(32'd20, 32'hFFFF_FFFF));
        send_item(sample_item(14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF));
        send_item(sample_item(14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF));
        send_item(sample_item(14'd1, 14'd2, 14'd3, 14'd4));
        send_item(tick_item(32'd3000, 32'hFFFF_FFFF));
        send_item(sample_item(14'd10000, 14'd0, 14'd5000, 14'd9999));
        send_item(sample_item(14'd0, 14'd10000, 14'd6001, 14'd500));
        send_item(tick_item(32'hFFFF_FFF0, 32'd0));
        send_item(sample_item(14'h2AAA, 14'h1555, 14'd9000, 14'd499));
        send_item(sample_item(14'h1555, 14'h2AAA, 14'd9001, 14'd501));
        send_item(tick_item(32'd5, 32'd1));
        send_item(sample_item(14'd8191, 14'd8192, 14'd1, 14'd2));
        send_item(sample_item(14'd8192, 14'd8191, 14'd2, 14'd1));
        cur_ms = 32'd5;
        last_frames = 32'd1;

        for (int stage = 0; stage < NUM_SETTINGS; stage++) begin
            quiesce();
            apply_setting(stage);
            goal = model.effective + ITEMS_PER_SETTING;
            if (stage == 4) hold_request = 1'b1;
            if (stage == 5) begin
                run_random(model.effective + ITEMS_PER_SETTING / 2);
                quiesce();
            end
            run_random(goal);
        end

        quiesce();
        $display("sent %0d items (%0d acted on) across %0d register settings",
                 items_sent, model.effective, NUM_SETTINGS + 1);
        $display("checked %0d measurement and %0d watchdog results, %0d mismatches",
                 model.measurements, model.watchdog_resets, model.mismatches);
        if (model.mismatches == 0 && model.pending() == 0) begin
            $display("averaging_window_alarm_monitor test passed");
        end else begin
            $display("averaging_window_alarm_monitor test failed");
        end
        $finish;
    end

endmodule

FILE: averaging_window_alarm_monitor.f
+incdir+rtl
rtl/awam_pkg.sv
rtl/awam_div.sv
rtl/awam_lane.sv
rtl/averaging_window_alarm_monitor.sv
verif/averaging_window_alarm_monitor_test.sv
